// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // job queue between the classifier and the output serializer
    localparam int QDEPTH = 2;

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2f;

    // escape letters
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_N = 8'h6e;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_R = 8'h72;
    // characters they stand for
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0a;
    localparam logic [7:0] CODE_FF  = 8'h0c;
    localparam logic [7:0] CODE_CR  = 8'h0d;
    // hex digit ranges
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    localparam logic [15:0] UTF8_MAX1 = 16'h0080;
    localparam logic [15:0] UTF8_MAX2 = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hc0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'he0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  MASK5 = 8'h1f;
    localparam logic [7:0]  MASK6 = 8'h3f;
    localparam logic [7:0]  MASK4 = 8'h0f;

    // one accepted item turned into 1..4 results
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      cnt_m1;    // number of results minus one
        logic            has_data;  // 0: single empty end marker
        logic            last;      // final item of the string
    } t_job;

    // {ok, char} for single-character escapes
    function automatic logic [8:0] escape_map(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_B:      r = {1'b1, CODE_BS};
            CH_T:      r = {1'b1, CODE_TAB};
            CH_N:      r = {1'b1, CODE_LF};
            CH_F:      r = {1'b1, CODE_FF};
            CH_R:      r = {1'b1, CODE_CR};
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_SLASH:  r = {1'b1, CH_SLASH};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            default:   r = 9'h000;
        endcase
        return r;
    endfunction

    // {ok, value} for a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, 4'(c - CH_ZERO)};
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
        end else begin
            r = 5'h00;
        end
        return r;
    endfunction

endpackage

// ===== rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw bytes, tracks escape state and turns each byte that yields output or ends the string into a job.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job
);

    typedef enum logic [1:0] {MODE_NORMAL, MODE_ESCAPE, MODE_HEX} t_mode;

    t_mode       r_mode, n_mode;
    logic [15:0] r_hex_value, n_hex_value;
    logic [1:0]  r_hex_count, n_hex_count;
    logic        r_hex_stopped, n_hex_stopped;
    logic [7:0]  r_held [3];
    logic [7:0]  n_held [3];

    logic            accept;
    logic [3:0][7:0] list;
    logic [2:0]      cnt;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        logic [8:0]  em;
        logic [4:0]  hd;
        logic [2:0]  cnt_n;
        logic [15:0] v;
        logic        esc;
        logic [7:0]  c;
        n_mode        = r_mode;
        n_hex_value   = r_hex_value;
        n_hex_count   = r_hex_count;
        n_hex_stopped = r_hex_stopped;
        n_held        = r_held;
        list          = '0;
        cnt           = 3'd0;
        em            = escape_map(i_byte);
        hd            = hex_digit(i_byte);
        cnt_n         = {1'b0, r_hex_count} + 3'd1;
        v             = r_hex_value;
        esc           = 1'b0;
        c             = 8'h00;

        case (r_mode)
            MODE_NORMAL: begin
                if (i_byte == CH_BSLASH) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    list[0] = i_byte;
                    cnt     = 3'd1;
                end
            end
            MODE_ESCAPE: begin
                if (i_byte == CH_U) begin
                    n_mode        = MODE_HEX;
                    n_hex_value   = 16'h0000;
                    n_hex_count   = 2'd0;
                    n_hex_stopped = 1'b0;
                end else begin
                    if (em[8]) begin
                        list[0] = em[7:0];
                        cnt     = 3'd1;
                    end
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_HEX: begin
                if (r_hex_count != 2'd3) begin
                    n_held[r_hex_count] = i_byte;
                end
                if (!r_hex_stopped && hd[4]) begin
                    v = {r_hex_value[11:0], hd[3:0]};
                end else begin
                    n_hex_stopped = 1'b1;
                end
                n_hex_value = v;
                if (cnt_n[2]) begin
                    if (v < UTF8_MAX1) begin
                        list[0] = v[7:0];
                        cnt     = 3'd1;
                    end else if (v < UTF8_MAX2) begin
                        list[0] = (8'(v >> 6) & MASK5) | UTF8_LEAD2;
                        list[1] = (v[7:0] & MASK6) | UTF8_CONT;
                        cnt     = 3'd2;
                    end else begin
                        list[0] = (8'(v >> 12) & MASK4) | UTF8_LEAD3;
                        list[1] = (8'(v >> 6) & MASK6) | UTF8_CONT;
                        list[2] = (v[7:0] & MASK6) | UTF8_CONT;
                        cnt     = 3'd3;
                    end
                    n_mode        = MODE_NORMAL;
                    n_hex_value   = 16'h0000;
                    n_hex_count   = 2'd0;
                    n_hex_stopped = 1'b0;
                end else begin
                    n_hex_count = cnt_n[1:0];
                end
            end
            default: begin
                n_mode = MODE_NORMAL;
            end
        endcase

        if (i_last) begin
            // string ended inside a u escape: emit 'u' and replay held chars
            if (n_mode == MODE_HEX) begin
                list[0] = CH_U;
                cnt     = 3'd1;
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) < n_hex_count) begin
                        c = n_held[k];
                        em = escape_map(c);
                        if (esc) begin
                            esc = 1'b0;
                            if (c == CH_U) begin
                                list[cnt[1:0]] = CH_U;
                                cnt = cnt + 3'd1;
                            end else if (em[8]) begin
                                list[cnt[1:0]] = em[7:0];
                                cnt = cnt + 3'd1;
                            end
                        end else if (c == CH_BSLASH) begin
                            esc = 1'b1;
                        end else begin
                            list[cnt[1:0]] = c;
                            cnt = cnt + 3'd1;
                        end
                    end
                end
            end
            n_mode        = MODE_NORMAL;
            n_hex_value   = 16'h0000;
            n_hex_count   = 2'd0;
            n_hex_stopped = 1'b0;
        end
    end

    assign o_push          = accept && (cnt != 3'd0 || i_last);
    assign o_job.bytes     = list;
    assign o_job.cnt_m1    = (cnt == 3'd0) ? 2'd0 : 2'(cnt - 3'd1);
    assign o_job.has_data  = (cnt != 3'd0);
    assign o_job.last      = i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_NORMAL;
            r_hex_value   <= 16'h0000;
            r_hex_count   <= 2'd0;
            r_hex_stopped <= 1'b0;
        end else if (accept) begin
            r_mode        <= n_mode;
            r_hex_value   <= n_hex_value;
            r_hex_count   <= n_hex_count;
            r_hex_stopped <= n_hex_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

// ===== rtl/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Small job fifo between the classifier and the output serializer.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("job pushed into full queue");

endmodule

// ===== rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Serializes queued jobs into output items through an output register.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tuser,
    output logic       o_tlast
);

    logic       r_tvalid;
    logic [7:0] r_tdata;
    logic       r_tuser;
    logic       r_tlast;
    logic [1:0] r_idx, n_idx;
    logic       load_ok;
    logic       at_end;

    assign load_ok = !r_tvalid || i_tready;
    assign at_end  = (r_idx == i_job.cnt_m1);
    assign o_pop   = load_ok && i_q_valid && at_end;

    always_comb begin
        n_idx = r_idx;
        if (load_ok && i_q_valid) begin
            n_idx = at_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_idx    <= 2'd0;
        end else begin
            r_idx <= n_idx;
            if (load_ok) begin
                r_tvalid <= i_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok && i_q_valid) begin
            r_tdata <= i_job.bytes[r_idx];
            r_tuser <= i_job.has_data;
            r_tlast <= i_job.last && at_end;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

    // result index never runs past the head job
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> r_idx <= i_job.cnt_m1)
        else $error("result index beyond job length");

    // empty end marker is always the closing item with a zero byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tvalid && !r_tuser |-> r_tlast && r_tdata == 8'h00)
        else $error("malformed empty end marker");

    // index only moves while a job is being served
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |=> r_idx == 2'd0 || $past(r_idx) == r_idx)
        else $error("result index moved without a job");

endmodule

// ===== rtl/json_string_unescape_core.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Byte-serial JSON string body unescaper with UTF-8 output for u escapes.
//
//  channel   direction  tdata        tuser      tlast
//  s         in         in_byte      -          in_last
//  m         out        out_byte     out_valid  out_last
//
// one input byte is taken per cycle while the job queue is not full; an item
// giving k results (up to 4) is sent as k items by the single-byte output register
// a two-entry job queue lets input keep flowing while results drain
// an accepted item enters the job queue; its first result then goes to the output register
// reset is synchronous, active low; no clearing pass is needed
// ----------------------------------------------------------------------------
module json_string_unescape_core import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tuser,   // [0] out_valid
    output logic       o_m_tlast
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_q_full (q_full),
        .o_ready  (o_s_tready),
        .o_push   (push),
        .o_job    (push_job)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    jsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_tdata   (o_m_tdata),
        .o_tuser   (o_m_tuser),
        .o_tlast   (o_m_tlast)
    );

endmodule
